// ===== rtl/nat_pkg.sv =====
// ----------------------------------------------------------------------------
// nat_pkg
// Shared types and constants for the neighbor address table.
// ----------------------------------------------------------------------------
package nat_pkg;

	localparam int CMD_W    = 2;
	localparam int KEY_W    = 64;
	localparam int STATUS_W = 3;
	localparam int INDEX_W  = 9;
	localparam int THRESH_W = 10;

	localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd256;

	typedef enum logic [CMD_W-1:0] {
		CMD_INTERN = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_RSVD   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND     = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_REMOVED   = 3'd4
	} status_t;

endpackage

// ===== rtl/nat_req_if.sv =====
// ----------------------------------------------------------------------------
// nat_req_if
// Request channel: command and 128-bit key as two halves.
// ----------------------------------------------------------------------------
interface nat_req_if;
	logic                       valid;
	logic                       ready;
	logic [nat_pkg::CMD_W-1:0]  cmd;
	logic [nat_pkg::KEY_W-1:0]  addr_high;
	logic [nat_pkg::KEY_W-1:0]  addr_low;

	modport source (output valid, cmd, addr_high, addr_low, input ready);
	modport sink   (input valid, cmd, addr_high, addr_low, output ready);
endinterface

// ===== rtl/nat_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nat_rsp_if
// Response channel: status, entry index and crowded flag.
// ----------------------------------------------------------------------------
interface nat_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [nat_pkg::STATUS_W-1:0]  status;
	logic [nat_pkg::INDEX_W-1:0]   entry_index;
	logic                          crowded;

	modport source (output valid, status, entry_index, crowded, input ready);
	modport sink   (input valid, status, entry_index, crowded, output ready);
endinterface

// ===== rtl/nat_table_mem.sv =====
// ----------------------------------------------------------------------------
// nat_table_mem
// Single-port-write, single-port-read table RAM, registered read data.
// ----------------------------------------------------------------------------
module nat_table_mem #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 129
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/neighbor_address_table_unit.sv =====
// ----------------------------------------------------------------------------
// neighbor_address_table_unit
// Table of IPv6 neighbor addresses with intern, find and remove requests.
// ----------------------------------------------------------------------------
// Scan: intern and find end early at the first valid match. The scan reads
//   one entry per cycle from the single read port of the table RAM.
// Throughput: one transaction in flight at a time.
// Reset: arst_n clears control state, sets crowd threshold to 256, then a
//   clearing pass invalidates every entry; no request is taken until it
//   ends (threshold writes are taken throughout).
// ----------------------------------------------------------------------------
module neighbor_address_table_unit #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	nat_req_if.sink                        req,
	nat_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [nat_pkg::THRESH_W-1:0]   cfg_wdata
);

	localparam int IW   = $clog2(TABLE_DEPTH);
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int KW   = nat_pkg::KEY_W;
	localparam int EW   = 1 + 2 * KW;                 // {valid, key_high, key_low}
	localparam int XW   = nat_pkg::INDEX_W;
	localparam int TW   = nat_pkg::THRESH_W;
	localparam int CMPW = (CW > TW) ? CW : TW;
	localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t                  state_q;

	// scan control
	logic [IW-1:0]           ptr_q;         // next address to issue
	logic                    issued_all_q;
	logic                    vld_s1;        // read data for idx_s1 is back
	logic [IW-1:0]           idx_s1;
	logic [EW-1:0]           rd_data_s1;

	// current request
	nat_pkg::cmd_t           cmd_q;
	logic [KW-1:0]           key_hi_q;
	logic [KW-1:0]           key_lo_q;

	// scan results
	logic                    found_q;
	logic [IW-1:0]           found_idx_q;
	logic                    free_found_q;
	logic [IW-1:0]           free_idx_q;
	logic [CW-1:0]           count_q;

	logic [TW-1:0]           thresh_q;

	// response register
	logic                    rsp_valid_q;
	nat_pkg::status_t        rsp_status_q;
	logic [XW-1:0]           rsp_index_q;
	logic                    rsp_crowded_q;

	// memory port
	logic                    wr_en;
	logic [IW-1:0]           wr_addr;
	logic [EW-1:0]           wr_data;

	// entry evaluation
	logic                    ent_valid;
	logic                    hit;
	logic                    is_last;
	logic                    finish;
	logic                    issue;
	logic                    ins_free;
	logic [IW-1:0]           ins_idx;
	logic                    req_fire;
	logic                    rsp_load;

	// result assembly
	nat_pkg::status_t        res_status;
	logic [IW-1:0]           res_idx;
	logic [IW+XW-1:0]        res_idx_ext;
	logic                    res_crowded;

	nat_table_mem #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (EW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (ptr_q),
		.rd_data (rd_data_s1)
	);

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.entry_index = rsp_index_q;
	assign rsp.crowded     = rsp_crowded_q;

	// Entry returned by the RAM this cycle; only valid entries can match.
	assign ent_valid = rd_data_s1[EW-1];
	assign hit       = vld_s1 && ent_valid
		&& (rd_data_s1[2*KW-1:KW] == key_hi_q)
		&& (rd_data_s1[KW-1:0] == key_lo_q);
	assign is_last   = (idx_s1 == LAST);

	// Intern and find stop at the first match; remove walks the whole table.
	assign finish = (state_q == S_SCAN) && vld_s1
		&& ((hit && (cmd_q != nat_pkg::CMD_REMOVE)) || is_last);
	assign issue  = (state_q == S_SCAN) && !issued_all_q && !finish;

	// Free slot to use if intern ends without a match; the last entry counts.
	assign ins_free = (vld_s1 && !ent_valid) ? 1'b1 : free_found_q;
	assign ins_idx  = (vld_s1 && !ent_valid) ? idx_s1 : free_idx_q;

	// Write port: clearing pass, remove invalidate, intern insert.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = '0;
		priority if (state_q == S_CLEAR) begin
			wr_en = 1'b1;
		end else if ((state_q == S_SCAN) && hit && (cmd_q == nat_pkg::CMD_REMOVE)) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1;
			wr_data = {1'b0, key_hi_q, key_lo_q};
		end else if (finish && !hit && ins_free && (cmd_q == nat_pkg::CMD_INTERN)) begin
			wr_en   = 1'b1;
			wr_addr = ins_idx;
			wr_data = {1'b1, key_hi_q, key_lo_q};
		end else begin
			wr_en = 1'b0;
		end
	end

	// Final result, formed once the scan registers have settled.
	always_comb begin
		res_status  = nat_pkg::ST_NOT_FOUND;
		res_idx     = '0;
		res_crowded = 1'b0;
		unique case (cmd_q)
			nat_pkg::CMD_INTERN: begin
				res_crowded = (CMPW'(count_q) > CMPW'(thresh_q));
				priority if (found_q) begin
					res_status = nat_pkg::ST_FOUND;
					res_idx    = found_idx_q;
				end else if (free_found_q) begin
					res_status = nat_pkg::ST_INSERTED;
					res_idx    = free_idx_q;
				end else begin
					res_status = nat_pkg::ST_FULL;
				end
			end
			nat_pkg::CMD_FIND: begin
				if (found_q) begin
					res_status = nat_pkg::ST_FOUND;
					res_idx    = found_idx_q;
				end
			end
			nat_pkg::CMD_REMOVE: begin
				res_status = nat_pkg::ST_REMOVED;
			end
			default: begin
				res_status = nat_pkg::ST_NOT_FOUND;
			end
		endcase
		// index is reported modulo 512
		res_idx_ext = {{XW{1'b0}}, res_idx};
	end

	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= nat_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	// Sequencer and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			ptr_q        <= '0;
			issued_all_q <= 1'b0;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			count_q      <= '0;
		end else begin
			vld_s1 <= issue;
			unique case (state_q)
				S_CLEAR: begin
					if (ptr_q == LAST) begin
						ptr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + IW'(1);
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						ptr_q        <= '0;
						issued_all_q <= 1'b0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						count_q      <= '0;
						state_q      <= (nat_pkg::cmd_t'(req.cmd) == nat_pkg::CMD_RSVD)
							? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						if (ptr_q == LAST) begin
							issued_all_q <= 1'b1;
						end else begin
							ptr_q <= ptr_q + IW'(1);
						end
					end
					if (vld_s1) begin
						if (!ent_valid) begin
							free_found_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
						if (hit) begin
							found_q <= 1'b1;
						end
					end
					if (finish) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// Request payload and scan indexes; no reset needed
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q    <= nat_pkg::cmd_t'(req.cmd);
			key_hi_q <= req.addr_high;
			key_lo_q <= req.addr_low;
		end
		if (issue) begin
			idx_s1 <= ptr_q;
		end
		if ((state_q == S_SCAN) && vld_s1) begin
			if (!ent_valid) begin
				free_idx_q <= idx_s1;
			end
			if (hit) begin
				found_idx_q <= idx_s1;
			end
		end
	end

	// Response register: a held transaction is kept until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q  <= res_status;
			rsp_index_q   <= res_idx_ext[XW-1:0];
			rsp_crowded_q <= res_crowded;
		end
	end

endmodule
